FILE: src/nhe_pkg.sv
// shared types and constants for the nonzero histogram equalization block
// no dependencies; used by scoped name by every module of the block but nhe_div

package nhe_pkg;

  localparam int PIX_W          = 8;
  localparam int BINS           = 256;
  localparam int ADDR_W         = 8;
  localparam int MAX_PIXELS_DEF = 131072;

  typedef enum logic {
    OP_ACCUMULATE = 1'b0,
    OP_MAP        = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC_WR,
    ST_ACC_WR_LAST,
    ST_TBL_RD,
    ST_TBL_ACC,
    ST_TBL_MUL,
    ST_TBL_DIV,
    ST_TBL_WR
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic in_take;
    logic acc_wr;
    logic tbl_start;
    logic tbl_rd;
    logic tbl_acc;
    logic tbl_mul;
    logic tbl_wr;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic can_count;
    logic out_hold;
    logic div_done;
    logic tbl_last;
  } sts_t;

endpackage

FILE: src/nonzero_histogram_equalization.sv
// Histogram equalization of 8-bit grey frames that skips zero (masked) pixels.
// Each frame is sent twice: an accumulate pass (operation 0) that gives no output
// beats, then a map pass (operation 1) that gives one beat per pixel, with zero
// pixels passing as zero. Map pixels go through at one per cycle behind a single
// output register while the output is not stalled. A counted accumulate pixel
// passes a write state for the read-modify-write on the histogram memory before
// the next is taken; a zero pixel, or one past MAX_PIXELS, does not. The last
// accumulate pixel rebuilds the 256-entry table by read, accumulate, multiply,
// divide and write for each entry, with input stalled; the divider gives one bit
// per cycle. Reset and the last map pixel clear the histogram; no clearing pass.
// depends on nhe_pkg, nhe_ctrl, nhe_datapath

module nonzero_histogram_equalization #(
  parameter int MAX_PIXELS = nhe_pkg::MAX_PIXELS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      operation,
  input  logic [nhe_pkg::PIX_W-1:0] pixel,
  input  logic                      last,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [nhe_pkg::PIX_W-1:0] mapped_pixel,
  output logic                      last_out
);

  nhe_pkg::cmd_t cmd;
  nhe_pkg::sts_t sts;

  nhe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .operation (operation),
    .last      (last),
    .sts       (sts),
    .in_stall  (in_stall),
    .cmd       (cmd)
  );

  nhe_datapath #(
    .MAX_PIXELS (MAX_PIXELS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .operation    (operation),
    .pixel        (pixel),
    .last         (last),
    .cmd          (cmd),
    .sts          (sts),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .mapped_pixel (mapped_pixel),
    .last_out     (last_out)
  );

endmodule

FILE: src/nhe_div.sv
// restoring divider, one quotient bit per cycle, for the table build
// depends on nothing beyond its parameters

module nhe_div #(
  parameter int NUM_W = 27,
  parameter int DEN_W = 19,
  parameter int QUO_W = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [QUO_W-1:0] quot,
  output logic             done
);

  localparam int STEP_W = $clog2(QUO_W + 1);

  logic [NUM_W-1:0]  rem;
  logic [NUM_W-1:0]  dsh;
  logic [STEP_W-1:0] steps;

  // quotient is known to fit QUO_W bits, so the divisor starts at den << (QUO_W-1)
  always_ff @(posedge clk) begin
    if (load) begin
      rem  <= num;
      dsh  <= NUM_W'({den, {(QUO_W-1){1'b0}}});
      quot <= '0;
    end else if (steps != '0) begin
      if (rem >= dsh) begin
        rem  <= rem - dsh;
        quot <= {quot[QUO_W-2:0], 1'b1};
      end else begin
        quot <= {quot[QUO_W-2:0], 1'b0};
      end
      dsh <= dsh >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
    end else if (load) begin
      steps <= STEP_W'(QUO_W);
    end else if (steps != '0) begin
      steps <= steps - STEP_W'(1);
    end
  end

  assign done = (steps == '0);

endmodule

FILE: src/nhe_datapath.sv
// histogram and mapping memories, counters, table build arithmetic, output register
// depends on nhe_pkg and nhe_div

module nhe_datapath #(
  parameter int MAX_PIXELS = nhe_pkg::MAX_PIXELS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       operation,
  input  logic [nhe_pkg::PIX_W-1:0]  pixel,
  input  logic                       last,
  input  nhe_pkg::cmd_t              cmd,
  output nhe_pkg::sts_t              sts,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [nhe_pkg::PIX_W-1:0]  mapped_pixel,
  output logic                       last_out
);

  // bins and cumulative sums never exceed the nonzero total
  localparam int CNT_W = $clog2(MAX_PIXELS + 1);
  localparam int NUM_W = CNT_W + 9;
  localparam int DEN_W = CNT_W + 1;

  logic [CNT_W-1:0]            bin_mem [nhe_pkg::BINS];
  logic [nhe_pkg::BINS-1:0]    bin_vld;
  logic [CNT_W-1:0]            bin_rd;
  logic                        bin_rd_vld;
  logic [nhe_pkg::ADDR_W-1:0]  bin_rd_addr;
  logic                        bin_rd_en;
  logic [CNT_W-1:0]            bin_eff;
  logic [nhe_pkg::ADDR_W-1:0]  acc_addr;

  logic [CNT_W-1:0]            total;
  logic [CNT_W-1:0]            cum;
  logic [nhe_pkg::ADDR_W-1:0]  idx;

  logic [nhe_pkg::PIX_W-1:0]   map_mem [nhe_pkg::BINS];
  logic [nhe_pkg::PIX_W-1:0]   map_rd;
  logic                        tbl_ok;
  logic                        map_hit;
  logic [nhe_pkg::PIX_W-1:0]   tbl_val;

  logic [NUM_W-1:0]            num;
  logic [DEN_W-1:0]            den;
  logic [nhe_pkg::PIX_W-1:0]   quot;
  logic                        div_done;

  logic                        is_map;
  logic                        can_count;
  logic                        count_take;
  logic                        map_take;

  assign is_map     = (nhe_pkg::op_t'(operation) == nhe_pkg::OP_MAP);
  assign can_count  = (pixel != '0) && (total < CNT_W'(MAX_PIXELS));
  assign count_take = cmd.in_take && !is_map && can_count;
  assign map_take   = cmd.in_take && is_map;

  // single read port shared by the pixel read-modify-write and the table sweep
  assign bin_rd_addr = cmd.tbl_rd ? idx : pixel;
  assign bin_rd_en   = cmd.tbl_rd || count_take;
  assign bin_eff     = bin_rd_vld ? bin_rd : '0;

  always_ff @(posedge clk) begin
    if (cmd.acc_wr) begin
      bin_mem[acc_addr] <= bin_eff + CNT_W'(1);
    end
    if (bin_rd_en) begin
      bin_rd     <= bin_mem[bin_rd_addr];
      bin_rd_vld <= bin_vld[bin_rd_addr];
    end
    if (count_take) begin
      acc_addr <= pixel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_vld <= '0;
      total   <= '0;
    end else if (map_take && last) begin
      bin_vld <= '0;
      total   <= '0;
    end else begin
      if (cmd.acc_wr) begin
        bin_vld[acc_addr] <= 1'b1;
      end
      if (count_take) begin
        total <= total + CNT_W'(1);
      end
    end
  end

  // table sweep: cumulative sum, then (510*cum + count) / (2*count)
  always_ff @(posedge clk) begin
    if (cmd.tbl_start) begin
      cum <= '0;
      idx <= '0;
    end else begin
      if (cmd.tbl_acc) begin
        cum <= cum + bin_eff;
      end
      if (cmd.tbl_wr) begin
        idx <= idx + nhe_pkg::ADDR_W'(1);
      end
    end
  end

  // 510*cum as (cum << 9) - (cum << 1)
  assign num = {cum, 9'd0} - NUM_W'({cum, 1'b0}) + NUM_W'(total);
  assign den = {total, 1'b0};

  nhe_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W),
    .QUO_W (nhe_pkg::PIX_W)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .load (cmd.tbl_mul),
    .num  (num),
    .den  (den),
    .quot (quot),
    .done (div_done)
  );

  // cum never exceeds count, so the quotient stays at or below 255
  assign tbl_val = (total == '0) ? '0 : quot;

  always_ff @(posedge clk) begin
    if (cmd.tbl_wr) begin
      map_mem[idx] <= tbl_val;
    end
    if (map_take) begin
      map_rd   <= map_mem[pixel];
      map_hit  <= (pixel != '0) && tbl_ok;
      last_out <= last;
    end
  end

  // table reads as all zero until the first build
  always_ff @(posedge clk) begin
    if (rst) begin
      tbl_ok <= 1'b0;
    end else if (cmd.tbl_wr) begin
      tbl_ok <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (map_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  assign mapped_pixel = map_hit ? map_rd : '0;

  assign sts.can_count = can_count;
  assign sts.out_hold  = out_valid && out_stall;
  assign sts.div_done  = div_done;
  assign sts.tbl_last  = (idx == '1);

endmodule

FILE: src/nhe_ctrl.sv
// controller state machine: input acceptance, histogram update and table sweep
// depends on nhe_pkg

module nhe_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          operation,
  input  logic          last,
  input  nhe_pkg::sts_t sts,
  output logic          in_stall,
  output nhe_pkg::cmd_t cmd
);

  nhe_pkg::state_t state;
  nhe_pkg::state_t state_next;
  logic            is_map;

  assign is_map = (nhe_pkg::op_t'(operation) == nhe_pkg::OP_MAP);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= nhe_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      nhe_pkg::ST_IDLE: begin
        // map beats wait only for the output register
        in_stall    = is_map && sts.out_hold;
        cmd.in_take = in_valid && !in_stall;
        if (cmd.in_take && !is_map) begin
          if (sts.can_count) begin
            state_next = last ? nhe_pkg::ST_ACC_WR_LAST : nhe_pkg::ST_ACC_WR;
          end else if (last) begin
            cmd.tbl_start = 1'b1;
            state_next    = nhe_pkg::ST_TBL_RD;
          end
        end
      end
      nhe_pkg::ST_ACC_WR: begin
        cmd.acc_wr = 1'b1;
        state_next = nhe_pkg::ST_IDLE;
      end
      nhe_pkg::ST_ACC_WR_LAST: begin
        cmd.acc_wr    = 1'b1;
        cmd.tbl_start = 1'b1;
        state_next    = nhe_pkg::ST_TBL_RD;
      end
      nhe_pkg::ST_TBL_RD: begin
        cmd.tbl_rd = 1'b1;
        state_next = nhe_pkg::ST_TBL_ACC;
      end
      nhe_pkg::ST_TBL_ACC: begin
        cmd.tbl_acc = 1'b1;
        state_next  = nhe_pkg::ST_TBL_MUL;
      end
      nhe_pkg::ST_TBL_MUL: begin
        cmd.tbl_mul = 1'b1;
        state_next  = nhe_pkg::ST_TBL_DIV;
      end
      nhe_pkg::ST_TBL_DIV: begin
        if (sts.div_done) begin
          state_next = nhe_pkg::ST_TBL_WR;
        end
      end
      nhe_pkg::ST_TBL_WR: begin
        cmd.tbl_wr = 1'b1;
        state_next = sts.tbl_last ? nhe_pkg::ST_IDLE : nhe_pkg::ST_TBL_RD;
      end
      default: begin
        state_next = nhe_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: src/nhe_checker.sv
// port-level assertions for nonzero_histogram_equalization, bound to the top level
// depends on nhe_pkg

module nhe_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_stall,
  input logic                      operation,
  input logic [nhe_pkg::PIX_W-1:0] pixel,
  input logic                      last,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic [nhe_pkg::PIX_W-1:0] mapped_pixel,
  input logic                      last_out
);

  logic map_beat;

  assign map_beat = in_valid && !in_stall &&
                    (nhe_pkg::op_t'(operation) == nhe_pkg::OP_MAP);

  // a held output beat keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(mapped_pixel) && $stable(last_out)))
    else $error("output beat changed while stalled");

  // output beats only come from map beats
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(map_beat))
    else $error("output beat without a map beat");

  // masked pixel maps to zero and carries its frame mark
  a_zero_pass: assert property (@(posedge clk) disable iff (rst)
    (map_beat && pixel == '0) |=> (out_valid && mapped_pixel == '0 && last_out == $past(last)))
    else $error("masked pixel not passed as zero");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind nonzero_histogram_equalization nhe_checker u_nhe_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .operation    (operation),
  .pixel        (pixel),
  .last         (last),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .mapped_pixel (mapped_pixel),
  .last_out     (last_out)
);

FILE: verif/nonzero_histogram_equalization_tb.sv
// self-checking testbench for nonzero_histogram_equalization: directed frames and
// random frames checked against an in-bench equalizer model
// depends on nhe_pkg and the nonzero_histogram_equalization top level
`timescale 1ns / 100ps

module nonzero_histogram_equalization_tb;

  localparam int PIX_LIMIT = nhe_pkg::MAX_PIXELS_DEF;

  typedef struct {
    nhe_pkg::op_t              op;
    logic [nhe_pkg::PIX_W-1:0] pix;
    logic                      lst;
    logic                      drain;    // hold this beat until every mapped beat is back
    logic                      hold_rx;  // starts the long receiver hold-off
  } beat_t;

  typedef struct {
    logic [nhe_pkg::PIX_W-1:0] pix_out;
    logic                      is_last;
  } mapped_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic                      operation = 1'b0;
  logic [nhe_pkg::PIX_W-1:0] pixel = '0;
  logic                      last = 1'b0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [nhe_pkg::PIX_W-1:0] mapped_pixel;
  logic                      last_out;

  beat_t   frame_beats[$];
  mapped_t pending_mapped[$];

  // equalizer model state
  logic [17:0]               hist [nhe_pkg::BINS];
  logic [17:0]               nz_total;
  logic [nhe_pkg::PIX_W-1:0] eq_lut [nhe_pkg::BINS];

  logic in_took = 1'b0;
  logic calm = 1'b0;
  logic hold_rx_req = 1'b0;
  int   err_cnt = 0;

  int   send_gap = 0;
  logic send_idle_on = 1'b1;
  int   stall_left = 0;
  int   hold_left = 0;
  logic hold_used = 1'b0;
  logic sink_idle_on = 1'b1;

  nonzero_histogram_equalization #(
    .MAX_PIXELS(PIX_LIMIT)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .operation    (operation),
    .pixel        (pixel),
    .last         (last),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .mapped_pixel (mapped_pixel),
    .last_out     (last_out)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  initial begin
    foreach (hist[i]) hist[i] = '0;
    foreach (eq_lut[i]) eq_lut[i] = '0;
    nz_total = '0;
  end

  // round(255 * cum / count) with halves up, clamped; all zero for an empty frame
  task automatic rebuild_lut();
    longint unsigned cnt, cum, v;
    cnt = nz_total;
    cum = 0;
    for (int i = 0; i < nhe_pkg::BINS; i++) begin
      if (cnt == 0) begin
        eq_lut[i] = '0;
      end else begin
        cum += hist[i];
        v = (510 * cum + cnt) / (2 * cnt);
        eq_lut[i] = (v > 255) ? 8'd255 : 8'(v);
      end
    end
  endtask

  task automatic equalize_pixel(nhe_pkg::op_t op, logic [nhe_pkg::PIX_W-1:0] px, logic lst);
    if (op == nhe_pkg::OP_ACCUMULATE) begin
      if (px != 0 && nz_total < PIX_LIMIT) begin
        hist[px] = hist[px] + 1'b1;
        nz_total = nz_total + 1'b1;
      end
      if (lst) rebuild_lut();
    end else begin
      pending_mapped.push_back('{pix_out: (px == 0) ? '0 : eq_lut[px], is_last: lst});
      if (lst) begin
        foreach (hist[i]) hist[i] = '0;
        nz_total = '0;
      end
    end
  endtask

  function automatic logic [nhe_pkg::PIX_W-1:0] pick_pixel(int mix);
    case (mix)
      0: return 8'($urandom_range(0, 255));
      1: begin
        case ($urandom_range(0, 3))
          0: return 8'd0;
          1: return 8'd1;
          2: return 8'd255;
          default: return 8'($urandom_range(0, 255));
        endcase
      end
      default: return ($urandom_range(0, 4) == 0) ? 8'd0 : 8'($urandom_range(96, 104));
    endcase
  endfunction

  task automatic queue_beat(nhe_pkg::op_t op, logic [nhe_pkg::PIX_W-1:0] px, logic lst,
                            logic drain = 1'b0, logic hold = 1'b0);
    frame_beats.push_back('{op: op, pix: px, lst: lst, drain: drain, hold_rx: hold});
  endtask

  task automatic queue_pass(nhe_pkg::op_t op, int n, int mix, logic lst_end, logic drain,
                            logic hold);
    for (int i = 0; i < n; i++)
      queue_beat(op, pick_pixel(mix), lst_end && i == n - 1, drain && i == 0, hold && i == 0);
  endtask

  // sender: a beat stays on the inputs until it is taken
  always @(negedge clk) begin : drive
    logic  nv;
    beat_t b;
    nv = in_valid;
    if ($urandom_range(0, 99) == 0) send_idle_on = !send_idle_on;
    if (!rst && (!in_valid || in_took)) begin
      nv = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
      end else if (frame_beats.size() != 0) begin
        b = frame_beats[0];
        if (!(b.drain && pending_mapped.size() != 0)) begin
          void'(frame_beats.pop_front());
          nv = 1'b1;
          operation <= b.op;
          pixel     <= b.pix;
          last      <= b.lst;
          if (b.hold_rx) hold_rx_req <= 1'b1;
          if (!calm && send_idle_on && $urandom_range(0, 7) == 0)
            send_gap = $urandom_range(1, 4);
        end
      end
    end
    in_valid <= nv;
    calm     <= frame_beats.size() < 250;
  end

  // receiver stall: short bursts, plus one long hold-off that fills the block
  always @(negedge clk) begin : sink
    logic ns;
    ns = 1'b0;
    if ($urandom_range(0, 99) == 0) sink_idle_on = !sink_idle_on;
    if (rst) begin
      ns = 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      ns = 1'b1;
    end else if (hold_rx_req && !hold_used) begin
      hold_used = 1'b1;
      hold_left = 199;
      ns = 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      ns = 1'b1;
    end else if (!calm && sink_idle_on && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 3);
      ns = 1'b1;
    end
    out_stall <= ns;
  end

  always @(posedge clk) begin : watch
    mapped_t want;
    in_took <= in_valid && !in_stall;
    if (!rst) begin
      if (in_valid && !in_stall) equalize_pixel(nhe_pkg::op_t'(operation), pixel, last);
      if (out_valid === 1'b1 && !out_stall) begin
        if (pending_mapped.size() == 0) begin
          $error("unexpected output beat: mapped_pixel %0d last_out %0b", mapped_pixel, last_out);
          err_cnt++;
        end else begin
          want = pending_mapped.pop_front();
          if (mapped_pixel !== want.pix_out) begin
            $error("mapped_pixel: expected %0d, got %0d", want.pix_out, mapped_pixel);
            err_cnt++;
          end
          if (last_out !== want.is_last) begin
            $error("last_out: expected %0b, got %0b", want.is_last, last_out);
            err_cnt++;
          end
        end
      end
    end
  end

  initial begin : main
    int   base, kind, n, m;
    logic drain, first;

    // map straight after reset: the table is still all zero
    queue_beat(nhe_pkg::OP_MAP, 8'd0, 1'b0);
    queue_beat(nhe_pkg::OP_MAP, 8'd1, 1'b0);
    queue_beat(nhe_pkg::OP_MAP, 8'd255, 1'b1);
    // empty frame, masked pixels only
    queue_beat(nhe_pkg::OP_ACCUMULATE, 8'd0, 1'b0);
    queue_beat(nhe_pkg::OP_ACCUMULATE, 8'd0, 1'b1);
    queue_beat(nhe_pkg::OP_MAP, 8'd128, 1'b1);
    // two accumulate passes add into one histogram
    queue_beat(nhe_pkg::OP_ACCUMULATE, 8'd1, 1'b0);
    queue_beat(nhe_pkg::OP_ACCUMULATE, 8'd255, 1'b0);
    queue_beat(nhe_pkg::OP_ACCUMULATE, 8'd255, 1'b0);
    queue_beat(nhe_pkg::OP_ACCUMULATE, 8'd128, 1'b1);
    queue_beat(nhe_pkg::OP_ACCUMULATE, 8'd7, 1'b0);
    queue_beat(nhe_pkg::OP_ACCUMULATE, 8'd0, 1'b1);
    queue_beat(nhe_pkg::OP_MAP, 8'd0, 1'b0);
    queue_beat(nhe_pkg::OP_MAP, 8'd1, 1'b0);
    queue_beat(nhe_pkg::OP_MAP, 8'd7, 1'b0);
    queue_beat(nhe_pkg::OP_MAP, 8'd128, 1'b0);
    queue_beat(nhe_pkg::OP_MAP, 8'd254, 1'b0);
    queue_beat(nhe_pkg::OP_MAP, 8'd255, 1'b1);
    // one counted pixel, then a map pass with no new accumulate keeps the table
    queue_beat(nhe_pkg::OP_ACCUMULATE, 8'd255, 1'b1);
    queue_beat(nhe_pkg::OP_MAP, 8'd254, 1'b0);
    queue_beat(nhe_pkg::OP_MAP, 8'd255, 1'b1);
    queue_beat(nhe_pkg::OP_MAP, 8'd128, 1'b1);

    base  = frame_beats.size();
    first = 1'b1;
    while (frame_beats.size() - base < 1780) begin
      kind  = first ? 0 : $urandom_range(0, 19);
      drain = first || $urandom_range(0, 9) == 0;
      n     = $urandom_range(1, 48);
      m     = first ? 80 : $urandom_range(1, 48);
      case (kind)
        16: queue_pass(nhe_pkg::OP_ACCUMULATE, n, $urandom_range(0, 2), 1'b1, drain, 1'b0);
        17: queue_pass(nhe_pkg::OP_MAP, m, $urandom_range(0, 1), 1'b1, drain, 1'b0);
        18: begin
          for (int i = 0; i < n % 10 + 1; i++)
            queue_beat(nhe_pkg::op_t'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                       1'($urandom_range(0, 1)), drain && i == 0);
        end
        default: begin
          // a broken frame drops the last marker of its accumulate pass
          queue_pass(nhe_pkg::OP_ACCUMULATE, n, $urandom_range(0, 2), kind != 19, drain, 1'b0);
          queue_pass(nhe_pkg::OP_MAP, m, $urandom_range(0, 1), 1'b1, 1'b0, first);
        end
      endcase
      first = 1'b0;
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (frame_beats.size() != 0 || in_valid) @(posedge clk);
    while (pending_mapped.size() != 0) @(posedge clk);
    // covers a table rebuild still running after the final beat
    repeat (4000) @(posedge clk);

    if (err_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin : watchdog
    #80_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

FILE: nonzero_histogram_equalization.f
src/nhe_pkg.sv
src/nhe_div.sv
src/nhe_datapath.sv
src/nhe_ctrl.sv
src/nonzero_histogram_equalization.sv
src/nhe_checker.sv
verif/nonzero_histogram_equalization_tb.sv
